FILE: design/pkthtbl_pkg.sv
// ----------------------------------------------------------------------------
// pkthtbl_pkg
// Shared constants and types of the per-read top-K hit table.
// ----------------------------------------------------------------------------
package pkthtbl_pkg;

    localparam int HITS_PER_READ = 8;
    localparam int NUM_READS     = 1024;

    localparam int READ_AW  = (NUM_READS > 1) ? $clog2(NUM_READS) : 1;
    localparam int SLOT_AW  = (HITS_PER_READ > 1) ? $clog2(HITS_PER_READ) : 1;
    localparam int RANK_W   = $clog2(HITS_PER_READ + 1);

    localparam int POS_W    = 29;
    localparam int IN_W     = 104;
    localparam int OUT_W    = 32;

    localparam logic signed [15:0] SCORE_MIN = 16'sh8000;
    localparam logic [10:0]        COUNT_MAX = 11'h7FF;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic signed [15:0] score;
        logic               vld;
        logic [7:0]         ref_idx;
        logic [POS_W-1:0]   start;
        logic [POS_W-1:0]   fin;
        logic [19:0]        bounds;
        logic               strand;
    } t_slot;

    typedef t_slot [HITS_PER_READ-1:0] t_row;

    localparam t_slot EMPTY_SLOT = '{score: SCORE_MIN, default: '0};

endpackage

FILE: design/per_key_top_k_hit_table.sv
// ----------------------------------------------------------------------------
// per_key_top_k_hit_table
// Per-read list of the best hits sorted by score, kept in a row-wide memory.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                                | tuser
// s_axis  | in  | read_index, reference_index, reference_base,      | opcode
//         |     | reference_offset_start, reference_offset_end,     |
//         |     | read_begin, read_finish, hit_score, reverse_strand|
// m_axis  | out | was_inserted, insert_rank, found_score,           | -
//         |     | reads_with_hits                                   |
//
// An item passes in order through row read, compare and update, and the
// next item is taken only after that update; the single read/modify/write
// pass over one memory row keeps items from overlapping.
// After reset a pass clears all 1024 touched bits; no item is taken.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits in the update step until the register frees.
module per_key_top_k_hit_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // read_index, reference_index, reference_base, reference_offset_start,
    // reference_offset_end, read_begin, read_finish, hit_score, reverse_strand
    input  logic [pkthtbl_pkg::IN_W-1:0]  i_s_axis_tdata,
    // opcode
    input  logic                          i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // was_inserted, insert_rank, found_score, reads_with_hits
    output logic [pkthtbl_pkg::OUT_W-1:0] o_m_axis_tdata
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CMP, S_WR} t_state;

    t_state r_state;
    logic [pkthtbl_pkg::READ_AW-1:0] r_clr_idx;

    pkthtbl_pkg::t_row r_row_mem [pkthtbl_pkg::NUM_READS];
    logic              r_touch_mem [pkthtbl_pkg::NUM_READS];
    pkthtbl_pkg::t_row r_row_rd;
    logic              r_touch_rd;

    logic                            r_op;
    logic [9:0]                      r_read;
    logic [7:0]                      r_ref;
    logic [pkthtbl_pkg::POS_W-1:0]   r_start;
    logic [pkthtbl_pkg::POS_W-1:0]   r_end;
    logic [19:0]                     r_bounds;
    logic signed [15:0]              r_score;
    logic                            r_strand;

    pkthtbl_pkg::t_row                     r_eff;
    logic [pkthtbl_pkg::HITS_PER_READ-1:0] r_match;
    logic [pkthtbl_pkg::HITS_PER_READ-1:0] r_gt;
    logic [pkthtbl_pkg::HITS_PER_READ-1:0] r_qm;
    logic [pkthtbl_pkg::HITS_PER_READ-1:0] n_match;
    logic [pkthtbl_pkg::HITS_PER_READ-1:0] n_gt;
    logic [pkthtbl_pkg::HITS_PER_READ-1:0] n_qm;
    pkthtbl_pkg::t_row                     n_eff;

    logic [10:0]                     r_count;
    logic                            r_out_valid;
    logic [pkthtbl_pkg::OUT_W-1:0]   r_out_data;

    logic [9:0]                    in_read;
    logic [7:0]                    in_ref;
    logic [pkthtbl_pkg::POS_W-1:0] in_base;
    logic [9:0]                    in_offs;
    logic [9:0]                    in_offe;
    logic                          accept;
    logic                          in_range;
    logic                          ins_ok;
    logic                          out_free;

    logic                           has_m;
    logic [pkthtbl_pkg::SLOT_AW-1:0] m_idx;
    logic [pkthtbl_pkg::RANK_W-1:0]  n_cnt;
    logic [pkthtbl_pkg::RANK_W-1:0]  kk;
    logic [pkthtbl_pkg::RANK_W-1:0]  p;
    logic                            rejected;
    logic                            has_q;
    logic signed [15:0]              q_score;
    pkthtbl_pkg::t_row               new_row;
    pkthtbl_pkg::t_slot              new_slot;
    logic [10:0]                     count_upd;

    assign in_read = i_s_axis_tdata[9:0];
    assign in_ref  = i_s_axis_tdata[17:10];
    assign in_base = i_s_axis_tdata[46:18];
    assign in_offs = i_s_axis_tdata[56:47];
    assign in_offe = i_s_axis_tdata[66:57];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign in_range = ({1'b0, r_read} < 11'(pkthtbl_pkg::NUM_READS));
    assign ins_ok   = in_range && (r_score != pkthtbl_pkg::SCORE_MIN);

    always_comb begin
        for (int j = 0; j < pkthtbl_pkg::HITS_PER_READ; j++) begin
            n_eff[j]   = r_touch_rd ? r_row_rd[j] : pkthtbl_pkg::EMPTY_SLOT;
            n_match[j] = n_eff[j].vld && (n_eff[j].ref_idx == r_ref) &&
                         (((n_eff[j].start == r_start) &&
                           (n_eff[j].bounds[9:0] == r_bounds[9:0])) ||
                          ((n_eff[j].fin == r_end) &&
                           (n_eff[j].bounds[19:10] == r_bounds[19:10])));
            n_gt[j]    = (r_score > n_eff[j].score);
            n_qm[j]    = n_eff[j].vld && (n_eff[j].ref_idx == r_ref) &&
                         (n_eff[j].start == r_start);
        end
    end

    always_comb begin
        has_m   = 1'b0;
        m_idx   = '0;
        n_cnt   = '0;
        has_q   = 1'b0;
        q_score = pkthtbl_pkg::SCORE_MIN;
        for (int j = pkthtbl_pkg::HITS_PER_READ - 1; j >= 0; j--) begin
            if (r_match[j]) begin
                has_m = 1'b1;
                m_idx = pkthtbl_pkg::SLOT_AW'(j);
            end
            if (r_qm[j]) begin
                has_q   = 1'b1;
                q_score = r_eff[j].score;
            end
        end
        for (int j = 0; j < pkthtbl_pkg::HITS_PER_READ; j++) begin
            n_cnt = n_cnt + pkthtbl_pkg::RANK_W'(r_eff[j].vld);
        end
        if (has_m) begin
            kk = pkthtbl_pkg::RANK_W'(m_idx);
        end else if (n_cnt == pkthtbl_pkg::RANK_W'(pkthtbl_pkg::HITS_PER_READ)) begin
            kk = pkthtbl_pkg::RANK_W'(pkthtbl_pkg::HITS_PER_READ - 1);
        end else begin
            kk = n_cnt;
        end
        p = '0;
        for (int j = 0; j < pkthtbl_pkg::HITS_PER_READ; j++) begin
            if ((j <= int'(kk)) && !r_gt[j]) begin
                p = pkthtbl_pkg::RANK_W'(j + 1);
            end
        end
        rejected = !ins_ok || (has_m && !r_gt[m_idx]) ||
                   (p == pkthtbl_pkg::RANK_W'(pkthtbl_pkg::HITS_PER_READ));
        new_slot = '{score: r_score, vld: 1'b1, ref_idx: r_ref, start: r_start,
                     fin: r_end, bounds: r_bounds, strand: r_strand};
        for (int j = 0; j < pkthtbl_pkg::HITS_PER_READ; j++) begin
            if (rejected || (j < int'(p)) || (j > int'(kk))) begin
                new_row[j] = r_eff[j];
            end else if (j == int'(p)) begin
                new_row[j] = new_slot;
            end else begin
                new_row[j] = r_eff[(j > 0) ? j - 1 : 0];
            end
        end
        count_upd = r_count;
        if (ins_ok && !r_touch_rd && (r_count != pkthtbl_pkg::COUNT_MAX)) begin
            count_upd = r_count + 11'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row_rd   <= r_row_mem[in_read[pkthtbl_pkg::READ_AW-1:0]];
            r_touch_rd <= r_touch_mem[in_read[pkthtbl_pkg::READ_AW-1:0]];
        end
        if (r_state == S_CLEAR) begin
            r_touch_mem[r_clr_idx] <= 1'b0;
        end else if ((r_state == S_WR) && out_free && (r_op == pkthtbl_pkg::OP_INSERT) &&
                     ins_ok) begin
            r_touch_mem[r_read[pkthtbl_pkg::READ_AW-1:0]] <= 1'b1;
            r_row_mem[r_read[pkthtbl_pkg::READ_AW-1:0]]   <= new_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_s_axis_tuser;
            r_read   <= in_read;
            r_ref    <= in_ref;
            r_start  <= (i_s_axis_tuser == pkthtbl_pkg::OP_QUERY) ? in_base :
                        in_base + pkthtbl_pkg::POS_W'(in_offs);
            r_end    <= in_base + pkthtbl_pkg::POS_W'(in_offe);
            r_bounds <= i_s_axis_tdata[86:67];
            r_score  <= i_s_axis_tdata[102:87];
            r_strand <= i_s_axis_tdata[103];
        end
        if (r_state == S_CMP) begin
            r_eff   <= n_eff;
            r_match <= n_match;
            r_gt    <= n_gt;
            r_qm    <= n_qm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == pkthtbl_pkg::READ_AW'(pkthtbl_pkg::NUM_READS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_op == pkthtbl_pkg::OP_INSERT) begin
                            r_count    <= count_upd;
                            r_out_data <= {count_upd, 16'd0,
                                           rejected ? 4'd0 : 4'(p), !rejected};
                        end else begin
                            r_out_data <= {r_count,
                                           (in_range && has_q) ? q_score
                                                               : pkthtbl_pkg::SCORE_MIN,
                                           4'd0, 1'b0};
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/pkthtbl_checker.sv
// ----------------------------------------------------------------------------
// pkthtbl_checker
// Port-level checks of the per-read top-K hit table.
// ----------------------------------------------------------------------------
module pkthtbl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [pkthtbl_pkg::OUT_W-1:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled item changed");

    a_rank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[0] |-> o_m_axis_tdata[4:1] == 4'd0)
        else $error("rank set on a rejected item");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready && !o_m_axis_tvalid)
        else $error("active right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second item taken while busy");

endmodule

bind per_key_top_k_hit_table pkthtbl_checker u_pkthtbl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
